// ===== design/hsl_pkg.sv =====
package hsl_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned HOFF_W    = 10;
    localparam int unsigned SLOFF_W   = 9;
    localparam int unsigned CFG_W     = 10;
    localparam int unsigned DIV_NUM_W = 17;
    localparam int unsigned DIV_Q_W   = 9;
    localparam int unsigned DIV_LAT   = DIV_Q_W;
    localparam int unsigned BACK_LAT  = 5;

    typedef enum logic [1:0] {
        REG_HUE_OFFSET        = 2'd0,
        REG_SATURATION_OFFSET = 2'd1,
        REG_LIGHTNESS_OFFSET  = 2'd2,
        REG_UNUSED            = 2'd3
    } t_reg_idx;

    // one register stage of the restoring divider (each divider instance has its own)
    typedef struct packed {
        logic [CH_W-1:0]      rem;
        logic [DIV_NUM_W-1:0] num;
        logic [CH_W-1:0]      den;
        logic [DIV_Q_W-1:0]   quo;
    } t_div_stage;

endpackage

// ===== design/hsl_div.sv =====
module hsl_div
    import hsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [CH_W-1:0]      i_den,
    output logic [DIV_Q_W-1:0]   o_quo
);

    // one quotient bit per stage; caller guarantees num < den * 2**DIV_Q_W
    t_div_stage r_st [DIV_LAT];
    t_div_stage n_st [DIV_LAT];

    always_comb begin
        t_div_stage   v_in;
        logic [CH_W:0] v_t;
        for (int i = 0; i < DIV_LAT; i++) begin
            if (i == 0) begin
                v_in.rem = i_num[DIV_NUM_W-1 -: CH_W];
                v_in.num = i_num;
                v_in.den = i_den;
                v_in.quo = '0;
            end else begin
                v_in = r_st[i-1];
            end
            v_t = {v_in.rem, v_in.num[DIV_Q_W-1-i]};
            n_st[i].num = v_in.num;
            n_st[i].den = v_in.den;
            if (v_t >= {1'b0, v_in.den}) begin
                n_st[i].rem = CH_W'(v_t - {1'b0, v_in.den});
                n_st[i].quo = {v_in.quo[DIV_Q_W-2:0], 1'b1};
            end else begin
                n_st[i].rem = v_t[CH_W-1:0];
                n_st[i].quo = {v_in.quo[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_quo = r_st[DIV_LAT-1].quo;

endmodule

// ===== design/hsl_pixel_adjust.sv =====
// hsl_pixel_adjust: hue/saturation/lightness adjust of an rgba pixel stream
//
// s_axis carries one pixel per transaction, m_axis returns the adjusted
// pixel. alpha is copied. the config port writes hue_offset (index 0),
// saturation_offset (1) and lightness_offset (2); write only while no
// pixel is in flight. with all offsets zero the pixel is returned as is.
//
// a pixel passes the forward stage, the two 9-stage hue/saturation
// dividers running side by side, the offset stage, five back-conversion
// stages and the output register. one pixel per clock is sustained while
// the receiver does not stall m_axis.
//
// synchronous reset (i_rst_n low) clears all stage valid bits and the
// offsets. when the receiver holds m_axis_tready low with a result
// pending, the whole pipeline freezes and s_axis_tready drops; nothing
// is lost or repeated.
module hsl_pixel_adjust
    import hsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // red_out, green_out, blue_out, alpha_out
);

    typedef struct packed {
        logic [31:0]     pix;
        logic            pass;
        logic            c0;
        logic [CH_W-1:0] l;
    } t_side;

    typedef struct packed {
        logic [31:0]     pix;
        logic            pass;
        logic [2:0]      sec;
        logic [5:0]      w;
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] l;
        logic [CH_W-1:0] k;
        logic [15:0]     p;
        logic [CH_W-1:0] c;
        logic [13:0]     xn;
        logic [CH_W-1:0] x;
    } t_back;

    logic signed [HOFF_W-1:0]  r_hoff;
    logic signed [SLOFF_W-1:0] r_soff;
    logic signed [SLOFF_W-1:0] r_loff;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hoff <= '0;
            r_soff <= '0;
            r_loff <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_HUE_OFFSET:        r_hoff <= i_cfg_data;
                REG_SATURATION_OFFSET: r_soff <= i_cfg_data[SLOFF_W-1:0];
                REG_LIGHTNESS_OFFSET:  r_loff <= i_cfg_data[SLOFF_W-1:0];
                REG_UNUSED:            ;
            endcase
        end
    end

    // ---------------- forward stage ----------------
    logic [CH_W-1:0]      a_r, a_g, a_b, a_mx, a_mn, a_c, a_den;
    logic [CH_W:0]        a_sum;
    logic signed [11:0]   a_t;
    logic [DIV_NUM_W-1:0] n_numh, n_nums;
    t_side                n_sd;

    always_comb begin
        a_r = s_axis_tdata[7:0];
        a_g = s_axis_tdata[15:8];
        a_b = s_axis_tdata[23:16];
        a_mx = (a_r > a_g) ? a_r : a_g;
        a_mn = (a_r < a_g) ? a_r : a_g;
        if (a_b > a_mx) a_mx = a_b;
        if (a_b < a_mn) a_mn = a_b;
        a_c   = a_mx - a_mn;
        a_sum = {1'b0, a_mx} + {1'b0, a_mn};
        a_den = (a_sum > 9'd255) ? CH_W'(9'd510 - a_sum) : a_sum[CH_W-1:0];
        priority if (a_mx == a_r) begin
            a_t = $signed({4'b0, a_g}) - $signed({4'b0, a_b});
            if (a_t < 0) a_t = a_t + $signed(12'(6 * a_c));
        end else if (a_mx == a_g) begin
            a_t = $signed({4'b0, a_b}) - $signed({4'b0, a_r}) + $signed(12'(2 * a_c));
        end else begin
            a_t = $signed({4'b0, a_r}) - $signed({4'b0, a_g}) + $signed(12'(4 * a_c));
        end
        n_numh = DIV_NUM_W'(a_t[10:0] * 17'd60);
        n_nums = DIV_NUM_W'({a_c, 8'b0} - {8'b0, a_c});
        n_sd.pix  = s_axis_tdata;
        n_sd.pass = (r_hoff == '0) && (r_soff == '0) && (r_loff == '0);
        n_sd.c0   = (a_c == '0);
        n_sd.l    = a_sum[CH_W:1];
    end

    logic                 r_va;
    logic [DIV_NUM_W-1:0] r_numh, r_nums;
    logic [CH_W-1:0]      r_denh, r_dens;
    t_side                r_sda;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numh <= n_numh;
            r_nums <= n_nums;
            r_denh <= a_c;
            r_dens <= a_den;
            r_sda  <= n_sd;
        end
    end

    // ---------------- dividers ----------------
    logic [DIV_Q_W-1:0] d_qh, d_qs;

    hsl_div u_div_h (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_numh),
        .i_den (r_denh),
        .o_quo (d_qh)
    );

    hsl_div u_div_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nums),
        .i_den (r_dens),
        .o_quo (d_qs)
    );

    logic  r_vd [DIV_LAT];
    t_side r_sdd [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_vd[i] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_va;
            for (int i = 1; i < DIV_LAT; i++) r_vd[i] <= r_vd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdd[0] <= r_sda;
            for (int i = 1; i < DIV_LAT; i++) r_sdd[i] <= r_sdd[i-1];
        end
    end

    // ---------------- offset stage ----------------
    t_side              o_sd;
    logic [8:0]         o_h0, o_h, o_hm;
    logic [CH_W-1:0]    o_s0;
    logic signed [10:0] o_hv, o_sv, o_lv;
    logic [8:0]         o_lt;
    t_back              n_b0;

    always_comb begin
        o_sd = r_sdd[DIV_LAT-1];
        o_h0 = o_sd.c0 ? '0 : d_qh;
        o_s0 = o_sd.c0 ? '0 : d_qs[CH_W-1:0];
        o_hv = $signed({2'b0, o_h0}) + 11'(r_hoff);
        priority if (o_hv < -11'sd360) o_hv = o_hv + 11'sd720;
        else if (o_hv < 0)              o_hv = o_hv + 11'sd360;
        else if (o_hv >= 11'sd720)      o_hv = o_hv - 11'sd720;
        else if (o_hv >= 11'sd360)      o_hv = o_hv - 11'sd360;
        else                            o_hv = o_hv;
        o_h = o_hv[8:0];
        o_sv = $signed({3'b0, o_s0}) + 11'(r_soff);
        o_lv = $signed({3'b0, o_sd.l}) + 11'(r_loff);
        n_b0 = '0;
        n_b0.pix  = o_sd.pix;
        n_b0.pass = o_sd.pass;
        n_b0.s = (o_sv < 0) ? '0 : (o_sv > 11'sd255) ? 8'd255 : o_sv[7:0];
        n_b0.l = (o_lv < 0) ? '0 : (o_lv > 11'sd255) ? 8'd255 : o_lv[7:0];
        o_lt = {n_b0.l, 1'b0};
        n_b0.k = (o_lt > 9'd255) ? CH_W'(9'd510 - o_lt) : o_lt[CH_W-1:0];
        priority if (o_h < 9'd60)  n_b0.sec = 3'd0;
        else if (o_h < 9'd120)     n_b0.sec = 3'd1;
        else if (o_h < 9'd180)     n_b0.sec = 3'd2;
        else if (o_h < 9'd240)     n_b0.sec = 3'd3;
        else if (o_h < 9'd300)     n_b0.sec = 3'd4;
        else                       n_b0.sec = 3'd5;
        priority if (o_h >= 9'd240) o_hm = o_h - 9'd240;
        else if (o_h >= 9'd120)     o_hm = o_h - 9'd120;
        else                        o_hm = o_h;
        n_b0.w = (o_hm >= 9'd60) ? 6'(9'd120 - o_hm) : 6'(o_hm);
    end

    // ---------------- back conversion ----------------
    logic  r_vb [BACK_LAT];
    t_back r_b  [BACK_LAT];
    t_back n_b  [BACK_LAT];
    logic [31:0] b_q255;
    logic [31:0] b_q15;
    logic [9:0]  b_m, b_vr, b_vg, b_vb;
    logic [CH_W-1:0] b_rr, b_gg, b_bb;

    function automatic logic [CH_W-1:0] chan(input logic [9:0] v, input logic [9:0] m);
        logic [10:0] sum;
        sum = {1'b0, v} + {1'b0, m};
        return (sum[10:1] > 10'd255) ? 8'd255 : sum[8:1];
    endfunction

    always_comb begin
        n_b[0] = n_b0;
        // s * k
        n_b[1]   = r_b[0];
        n_b[1].p = r_b[0].s * r_b[0].k;
        // c = p / 255 by reciprocal
        n_b[2]   = r_b[1];
        b_q255   = r_b[1].p * 32'd32897;
        n_b[2].c = b_q255[30:23];
        // x numerator
        n_b[3]    = r_b[2];
        n_b[3].xn = r_b[2].c * r_b[2].w;
        // x = xn / 60 as (xn / 4) / 15
        n_b[4]   = r_b[3];
        b_q15    = {20'b0, r_b[3].xn[13:2]} * 32'd34953;
        n_b[4].x = b_q15[26:19];
    end

    always_comb begin
        b_rr = '0;
        b_gg = '0;
        b_bb = '0;
        unique case (r_b[4].sec)
            3'd0:    begin b_rr = r_b[4].c; b_gg = r_b[4].x; end
            3'd1:    begin b_rr = r_b[4].x; b_gg = r_b[4].c; end
            3'd2:    begin b_gg = r_b[4].c; b_bb = r_b[4].x; end
            3'd3:    begin b_gg = r_b[4].x; b_bb = r_b[4].c; end
            3'd4:    begin b_rr = r_b[4].x; b_bb = r_b[4].c; end
            default: begin b_rr = r_b[4].c; b_bb = r_b[4].x; end
        endcase
        b_m  = {1'b0, r_b[4].l, 1'b0} - {2'b0, r_b[4].c};
        b_vr = {1'b0, b_rr, 1'b0};
        b_vg = {1'b0, b_gg, 1'b0};
        b_vb = {1'b0, b_bb, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BACK_LAT; i++) r_vb[i] <= 1'b0;
        end else if (en) begin
            r_vb[0] <= r_vd[DIV_LAT-1];
            for (int i = 1; i < BACK_LAT; i++) r_vb[i] <= r_vb[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < BACK_LAT; i++) r_b[i] <= n_b[i];
        end
    end

    // ---------------- output register ----------------
    logic        r_vo;
    logic [31:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vb[BACK_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_b[4].pass) begin
                r_out <= r_b[4].pix;
            end else begin
                r_out <= {r_b[4].pix[31:24], chan(b_vb, b_m), chan(b_vg, b_m),
                          chan(b_vr, b_m)};
            end
        end
    end

    // whole pipeline advances unless a result waits on a stalled receiver
    assign en            = !r_vo || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_out;

endmodule

// ===== design/hsl_checker.sv =====
module hsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is drained");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled transaction changed");

endmodule

bind hsl_pixel_adjust hsl_checker u_hsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
